FILE: rtl/alle_pkg.sv
// Package for the array linked list engine: sizes, operation and status codes,
// and the controller-to-datapath command structs. No dependencies.
package alle_pkg;

  localparam int SLOTS      = 128;
  localparam int VALUE_BITS = 32;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int USED_BITS  = $clog2(SLOTS + 1);

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [USED_BITS-1:0]  used_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT     = 3'd2;
  localparam logic [2:0] OP_ERASE      = 3'd3;
  localparam logic [2:0] OP_POP_FRONT  = 3'd4;
  localparam logic [2:0] OP_POP_BACK   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BADSLOT = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam slot_t HEAD = slot_t'(0);
  localparam slot_t TAIL = slot_t'(1);

  // Datapath micro-operations.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,      // latch inputs, read links of head, tail, idx
    DP_RESOLVE,      // pick victim / neighbors from read data
    DP_LINK_NEW,     // write new slot, bump count
    DP_UNLINK,       // splice victim out
    DP_READ_LAST,    // read links and value of last slot
    DP_MOVE,         // copy last into hole, repoint its neighbors
    DP_SHRINK,       // drop count
    DP_READ_ENDS,    // read head/tail links
    DP_READ_VALS,    // read front/back values
    DP_CLEAR         // clearing pass step
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] status;
    logic       report_slot;
  } alle_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       idx_ins_bad;
    logic       idx_era_bad;
    logic       victim_is_last;
    logic       clear_done;
  } alle_stat_t;

endpackage

FILE: rtl/alle_datapath.sv
// Datapath of the array linked list engine: link and value memories, slot
// count, working registers. Depends on alle_pkg.
module alle_datapath (
  input  logic                clk,
  input  logic                rst,
  input  alle_pkg::alle_cmd_t cmd,
  input  logic [2:0]          operation,
  input  alle_pkg::slot_t     slot_index,
  input  alle_pkg::value_t    item_value,
  output alle_pkg::alle_stat_t stat,
  output alle_pkg::slot_t     new_slot,
  output alle_pkg::value_t    front_value,
  output alle_pkg::value_t    back_value,
  output alle_pkg::slot_t     entry_count,
  output logic                is_empty
);
  import alle_pkg::*;

  // Link memories are read at several signal-chosen addresses, so they are
  // split per role into copies written identically; reads are registered.
  slot_t  nxt_a [SLOTS];
  slot_t  nxt_b [SLOTS];
  slot_t  prv_a [SLOTS];
  slot_t  prv_b [SLOTS];
  value_t val_a [SLOTS];
  value_t val_b [SLOTS];

  used_t  used;
  logic [2:0] op;
  slot_t  idx;
  value_t data;
  slot_t  victim;
  slot_t  vprev, vnext;     // neighbors of victim / insertion point
  slot_t  lprev, lnext;     // links of last slot
  value_t lval;
  slot_t  rd_n0, rd_p1, rd_pi, rd_ni;
  slot_t  clr;
  slot_t  front_slot, back_slot;

  slot_t  last_slot;
  assign last_slot = slot_t'(used - used_t'(1));

  // Links of the last slot as they stand after the victim is spliced out:
  // a neighbor that was the victim is replaced by the victim's own neighbor.
  slot_t  mprev, mnext;
  assign mprev = (lprev == victim) ? vprev : lprev;
  assign mnext = (lnext == victim) ? vnext : lnext;

  // Write ports: up to two link writes per step (nxt at wn_addr, prv at wp_addr) and
  // a second pair at wn2_addr/wp2_addr, written in the same step to both copies.
  logic   wn_en, wp_en, wn2_en, wp2_en, wv_en;
  slot_t  wn_addr, wn_data, wp_addr, wp_data, wn2_addr, wn2_data, wp2_addr, wp2_data;
  slot_t  wv_addr;
  value_t wv_data;

  always_comb begin
    wn_en = 1'b0; wp_en = 1'b0; wn2_en = 1'b0; wp2_en = 1'b0; wv_en = 1'b0;
    wn_addr = '0; wn_data = '0; wp_addr = '0; wp_data = '0;
    wn2_addr = '0; wn2_data = '0; wp2_addr = '0; wp2_data = '0;
    wv_addr = '0; wv_data = data;
    case (cmd.op)
      DP_LINK_NEW: begin
        // new slot s = last_slot+1 = used; links s<-vprev, s->vnext
        wn_en = 1'b1; wn_addr = slot_t'(used); wn_data = vnext;
        wp_en = 1'b1; wp_addr = slot_t'(used); wp_data = vprev;
        wn2_en = 1'b1; wn2_addr = vprev; wn2_data = slot_t'(used);
        wp2_en = 1'b1; wp2_addr = vnext; wp2_data = slot_t'(used);
        wv_en = 1'b1; wv_addr = slot_t'(used);
      end
      DP_UNLINK: begin
        wn2_en = 1'b1; wn2_addr = vprev; wn2_data = vnext;
        wp2_en = 1'b1; wp2_addr = vnext; wp2_data = vprev;
      end
      DP_MOVE: begin
        wn_en = 1'b1; wn_addr = victim; wn_data = mnext;
        wp_en = 1'b1; wp_addr = victim; wp_data = mprev;
        wn2_en = 1'b1; wn2_addr = mprev; wn2_data = victim;
        wp2_en = 1'b1; wp2_addr = mnext; wp2_data = victim;
        wv_en = 1'b1; wv_addr = victim; wv_data = lval;
      end
      DP_CLEAR: begin
        wn_en = 1'b1; wn_addr = clr; wn_data = (clr == HEAD) ? TAIL : HEAD;
        wp_en = 1'b1; wp_addr = clr; wp_data = HEAD;
      end
      default: ;
    endcase
  end

  // Writes: primary and secondary ports target distinct slots except when a
  // neighbor is the written slot itself, where the secondary must win.
  always_ff @(posedge clk) begin
    if (wn_en && !(wn2_en && wn2_addr == wn_addr)) begin
      nxt_a[wn_addr] <= wn_data; nxt_b[wn_addr] <= wn_data;
    end
    if (wn2_en) begin
      nxt_a[wn2_addr] <= wn2_data; nxt_b[wn2_addr] <= wn2_data;
    end
    if (wp_en && !(wp2_en && wp2_addr == wp_addr)) begin
      prv_a[wp_addr] <= wp_data; prv_b[wp_addr] <= wp_data;
    end
    if (wp2_en) begin
      prv_a[wp2_addr] <= wp2_data; prv_b[wp2_addr] <= wp2_data;
    end
    if (wv_en) begin
      val_a[wv_addr] <= wv_data; val_b[wv_addr] <= wv_data;
    end
  end

  // Registered reads.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        rd_n0 <= nxt_a[HEAD];
        rd_p1 <= prv_a[TAIL];
        rd_pi <= prv_b[slot_index];
        rd_ni <= nxt_b[slot_index];
      end
      DP_RESOLVE: begin
        // victim links (erase and pop) read from copy b
        rd_pi <= prv_b[victim];
        rd_ni <= nxt_b[victim];
      end
      DP_READ_LAST: begin
        lprev <= prv_a[last_slot];
        lnext <= nxt_a[last_slot];
        lval  <= val_a[last_slot];
      end
      DP_READ_ENDS: begin
        front_slot <= nxt_a[HEAD];
        back_slot  <= prv_b[TAIL];
      end
      DP_READ_VALS: begin
        front_value <= (used <= used_t'(2)) ? '0 : val_a[front_slot];
        back_value  <= (used <= used_t'(2)) ? '0 : val_b[back_slot];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= used_t'(2);
      clr  <= '0;
    end else begin
      case (cmd.op)
        DP_LINK_NEW: used <= used + used_t'(1);
        DP_SHRINK:   used <= used - used_t'(1);
        DP_CLEAR:    clr  <= clr + slot_t'(1);
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        op <= operation; idx <= slot_index; data <= item_value;
      end
      DP_RESOLVE: begin
        case (op)
          OP_PUSH_FRONT: begin vprev <= HEAD;  vnext <= rd_n0; end
          OP_PUSH_BACK:  begin vprev <= rd_p1; vnext <= TAIL;  end
          OP_INSERT:     begin vprev <= rd_pi; vnext <= idx;   end
          default: ;
        endcase
      end
      DP_UNLINK: ;
      default: ;
    endcase
    // after the victim link read, load its neighbors in the READ_LAST step
    if (cmd.op == DP_UNLINK) begin
      vprev <= vprev; vnext <= vnext;
    end
    if (cmd.op == DP_READ_LAST) begin
      vprev <= rd_pi; vnext <= rd_ni;
    end
  end

  // victim chosen from capture-cycle reads
  always_ff @(posedge clk) begin
    if (cmd.op == DP_RESOLVE) begin
      case (op)
        OP_POP_FRONT: victim <= rd_n0;
        OP_POP_BACK:  victim <= rd_p1;
        default:      victim <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LINK_NEW)     new_slot <= slot_t'(used);
    else if (cmd.op == DP_CAPTURE) new_slot <= '0;
  end

  assign entry_count = slot_t'(used - used_t'(2));
  assign is_empty    = (used <= used_t'(2));

  always_comb begin
    stat.empty          = (used <= used_t'(2));
    stat.full           = (used >= used_t'(SLOTS));
    stat.idx_ins_bad    = (idx == HEAD) || (used_t'(idx) >= used);
    stat.idx_era_bad    = (idx < slot_t'(2)) || (used_t'(idx) >= used);
    stat.victim_is_last = (victim == last_slot);
    stat.clear_done     = (clr == slot_t'(SLOTS - 1));
  end

endmodule

FILE: rtl/alle_ctrl.sv
// Controller of the array linked list engine: sequences datapath steps per
// item. Depends on alle_pkg.
module alle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2:0]           operation,
  input  alle_pkg::alle_stat_t stat,
  output alle_pkg::alle_cmd_t  cmd,
  output logic                 busy,
  output logic                 done,
  output logic [1:0]           status
);
  import alle_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_VREAD, S_UNLINK, S_LREAD, S_MOVE,
    S_SHRINK, S_LINK, S_ENDS, S_VALS, S_DONE
  } state_t;

  state_t     state;
  logic [2:0] op;
  logic [1:0] st;

  always_comb begin
    cmd.op = DP_NOP; cmd.status = st; cmd.report_slot = 1'b0;
    case (state)
      S_CLEAR:  cmd.op = DP_CLEAR;
      S_IDLE:   cmd.op = start ? DP_CAPTURE : DP_NOP;
      S_DECIDE: cmd.op = DP_RESOLVE;
      S_VREAD:  cmd.op = DP_RESOLVE;
      S_LREAD:  cmd.op = DP_READ_LAST;
      S_UNLINK: cmd.op = DP_UNLINK;
      S_MOVE:   cmd.op = DP_MOVE;
      S_SHRINK: cmd.op = DP_SHRINK;
      S_LINK:   begin cmd.op = DP_LINK_NEW; cmd.report_slot = 1'b1; end
      S_ENDS:   cmd.op = DP_READ_ENDS;
      S_VALS:   cmd.op = DP_READ_VALS;
      default:  cmd.op = DP_NOP;
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign status = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; op <= '0; st <= ST_OK; done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: if (stat.clear_done) state <= S_IDLE;
        S_IDLE: if (start) begin
          op <= operation; state <= S_DECIDE;
        end
        S_DECIDE: begin
          st <= ST_OK;
          state <= S_ENDS;
          case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
              if (stat.full) st <= ST_FULL; else state <= S_LINK;
            OP_INSERT:
              if (stat.idx_ins_bad) st <= ST_BADSLOT;
              else if (stat.full) st <= ST_FULL;
              else state <= S_LINK;
            OP_ERASE:
              if (stat.empty) st <= ST_EMPTY;
              else if (stat.idx_era_bad) st <= ST_BADSLOT;
              else state <= S_VREAD;
            OP_POP_FRONT, OP_POP_BACK:
              if (stat.empty) st <= ST_EMPTY; else state <= S_VREAD;
            default: st <= ST_BADSLOT;
          endcase
        end
        S_VREAD:  state <= S_LREAD;   // victim links read this cycle
        S_LREAD:  state <= S_UNLINK;  // neighbors loaded, last slot read
        S_UNLINK: state <= stat.victim_is_last ? S_SHRINK : S_MOVE;
        S_MOVE:   state <= S_SHRINK;
        S_SHRINK: state <= S_ENDS;
        S_LINK:   state <= S_ENDS;
        S_ENDS:   state <= S_VALS;
        S_VALS:   begin state <= S_DONE; done <= 1'b1; end
        S_DONE:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Splice and move must not run while the list is empty.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_UNLINK) |-> !stat.empty)
    else $error("unlink on empty list");
  // A result strobe follows the value read step.
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_VALS))
    else $error("strobe out of sequence");
  // Link a new slot only while the table has room.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> !stat.full)
    else $error("link into full table");

endmodule

FILE: rtl/array_linked_list_engine_core.sv
// Array linked list engine: 128-slot doubly linked list with packed slots.
// Push/insert: decide, link. Erase/pop: decide, victim read, last-slot read,
// unlink, move (skipped when the highest used slot goes), shrink. Then end
// link and end value reads, also for a rejected item; one item at a time.
// Reset (rst, synchronous): clearing pass restores head/tail links, busy high.
// The done strobe lasts one cycle; the receiver cannot stall it.
module array_linked_list_engine_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              operation,
  input  logic [6:0]              slot_index,
  input  logic [31:0]             item_value,
  output logic                    done,
  output logic [1:0]              status,
  output logic [6:0]              new_slot,
  output logic [31:0]             front_value,
  output logic [31:0]             back_value,
  output logic [6:0]              entry_count,
  output logic                    is_empty
);
  import alle_pkg::*;

  alle_cmd_t  cmd;
  alle_stat_t stat;

  // Sequence one item through the datapath steps.
  alle_ctrl u_ctrl (
    .clk, .rst, .start, .operation, .stat, .cmd, .busy, .done, .status
  );

  // Hold links, values and count; report ends after each item.
  alle_datapath u_dp (
    .clk, .rst, .cmd, .operation, .slot_index, .item_value, .stat,
    .new_slot, .front_value, .back_value, .entry_count, .is_empty
  );

endmodule
